>>> src/a2i_pkg.sv
// Shared types and constants for the ASCII-to-integer parser.
// Used by the front classifier, the token queue, the parse engine and the top level.
package a2i_pkg;

  // Width of the accumulated value and of the character counter.
  localparam int VALUE_BITS = 64;
  localparam int COUNT_BITS = 16;

  // Fixed port widths.
  localparam int CH_BITS        = 8;
  localparam int RADIX_BITS     = 6;
  localparam int OUT_VALUE_BITS = 64;
  localparam int OUT_COUNT_BITS = 16;
  localparam int DIGIT_BITS     = 6;
  localparam int INDEX_BITS     = 1;
  localparam int WDATA_BITS     = RADIX_BITS;

  // Largest consumed count the result port can show.
  localparam logic [31:0] CONSUMED_MAX = 32'h0000_FFFF;

  // Token queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [INDEX_BITS-1:0] REG_RADIX       = 1'b0;
  localparam logic [INDEX_BITS-1:0] REG_SIGNED_MODE = 1'b1;

  // Configuration reset values.
  localparam logic [RADIX_BITS-1:0] RADIX_RESET  = 6'd10;
  localparam logic                  SIGNED_RESET = 1'b1;

  // Bases.
  localparam logic [RADIX_BITS-1:0] BASE_AUTO = 6'd0;
  localparam logic [RADIX_BITS-1:0] BASE_OCT  = 6'd8;
  localparam logic [RADIX_BITS-1:0] BASE_DEC  = 6'd10;
  localparam logic [RADIX_BITS-1:0] BASE_HEX  = 6'd16;

  // Character codes.
  localparam logic [CH_BITS-1:0] CH_SPACE    = 8'h20;
  localparam logic [CH_BITS-1:0] CH_TAB      = 8'h09;
  localparam logic [CH_BITS-1:0] CH_CR       = 8'h0D;
  localparam logic [CH_BITS-1:0] CH_PLUS     = 8'h2B;
  localparam logic [CH_BITS-1:0] CH_MINUS    = 8'h2D;
  localparam logic [CH_BITS-1:0] CH_ZERO     = 8'h30;
  localparam logic [CH_BITS-1:0] CH_NINE     = 8'h39;
  localparam logic [CH_BITS-1:0] CH_UPPER_A  = 8'h41;
  localparam logic [CH_BITS-1:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [CH_BITS-1:0] CH_UPPER_X  = 8'h58;
  localparam logic [CH_BITS-1:0] CH_LOWER_A  = 8'h61;
  localparam logic [CH_BITS-1:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [CH_BITS-1:0] CH_LOWER_X  = 8'h78;
  localparam logic [CH_BITS-1:0] ALPHA_FIRST = 8'd10;

  // One classified character.
  typedef struct packed {
    logic                  is_space;
    logic                  is_plus;
    logic                  is_minus;
    logic                  is_x;
    logic                  is_digit;
    logic [DIGIT_BITS-1:0] digit;
  } token_t;

endpackage

>>> src/a2i_front.sv
// Front end: classifies each incoming character into a token for the queue.
// Depends on a2i_pkg for the token type and character codes.
module a2i_front import a2i_pkg::*; (
  input  logic               in_valid,
  input  logic [CH_BITS-1:0] ch,
  input  logic               full,
  output logic               in_stall,
  output logic               push,
  output token_t             token
);

  assign in_stall = full;
  assign push     = in_valid && !full;

  always_comb begin
    token          = '0;
    token.is_space = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
    token.is_plus  = (ch == CH_PLUS);
    token.is_minus = (ch == CH_MINUS);
    token.is_x     = (ch == CH_LOWER_X) || (ch == CH_UPPER_X);
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      token.is_digit = 1'b1;
      token.digit    = DIGIT_BITS'(ch - CH_ZERO);
    end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) begin
      token.is_digit = 1'b1;
      token.digit    = DIGIT_BITS'(ch - CH_LOWER_A + ALPHA_FIRST);
    end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      token.is_digit = 1'b1;
      token.digit    = DIGIT_BITS'(ch - CH_UPPER_A + ALPHA_FIRST);
    end
  end

endmodule

>>> src/a2i_queue.sv
// Short token queue that decouples the classifier from the parse engine.
// Depends on a2i_pkg for the token type and queue depth.
module a2i_queue import a2i_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  token_t push_data,
  input  logic   pop,
  output logic   full,
  output logic   not_empty,
  output token_t head
);

  token_t                entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]  wr_ptr;
  logic [QPTR_BITS-1:0]  rd_ptr;
  logic [QCNT_BITS-1:0]  count;

  assign full      = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> src/a2i_back.sv
// Parse engine: walks the token stream, accumulates digits and holds the result register.
// Depends on a2i_pkg for the token type, bases and widths.
module a2i_back import a2i_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [RADIX_BITS-1:0]     radix,
  input  logic                      signed_mode,
  input  logic                      tok_valid,
  input  token_t                    token,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [OUT_VALUE_BITS-1:0] value,
  output logic [OUT_COUNT_BITS-1:0] consumed
);

  typedef enum logic [1:0] {
    PH_SPACE,
    PH_START,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  phase_t                  phase, phase_next, eff;
  logic                    negative, negative_next;
  logic [RADIX_BITS-1:0]   active_base, active_base_next, base_use;
  logic [VALUE_BITS-1:0]   acc, acc_next, result;
  logic [COUNT_BITS-1:0]   count, count_next, count_inc;
  logic [VALUE_BITS+RADIX_BITS-1:0] prod_full;
  logic [31:0]             count_wide;
  logic                    step_done, emit, is_zero;

  assign count_inc  = (count == '1) ? count : count + 1'b1;
  assign is_zero    = token.is_digit && (token.digit == '0);
  assign prod_full  = acc * base_use;
  assign result     = (signed_mode && negative) ? ('0 - acc) : acc;
  assign count_wide = 32'(count);
  assign pop        = tok_valid && (!emit || !out_valid || !out_stall);

  always_comb begin
    phase_next       = phase;
    negative_next    = negative;
    active_base_next = active_base;
    acc_next         = acc;
    count_next       = count;
    eff              = phase;
    base_use         = active_base;
    step_done        = 1'b0;
    emit             = 1'b0;

    if (phase == PH_SPACE) begin
      if (token.is_space) begin
        count_next = count_inc;
        step_done  = 1'b1;
      end else if (token.is_plus || token.is_minus) begin
        negative_next = token.is_minus;
        count_next    = count_inc;
        phase_next    = PH_START;
        step_done     = 1'b1;
      end else begin
        eff = PH_START;
      end
    end

    if (!step_done) begin
      case (eff)
        PH_START: begin
          // A leading zero may open a base prefix when the base is automatic or hex.
          if ((radix == BASE_AUTO || radix == BASE_HEX) && is_zero) begin
            active_base_next = radix;
            acc_next         = '0;
            count_next       = count_inc;
            phase_next       = PH_ZERO;
            step_done        = 1'b1;
          end else begin
            base_use = (radix == BASE_AUTO) ? BASE_DEC : radix;
          end
        end
        PH_ZERO: begin
          if (token.is_x) begin
            active_base_next = BASE_HEX;
            count_next       = count_inc;
            phase_next       = PH_DIGITS;
            step_done        = 1'b1;
          end else begin
            base_use = (active_base == BASE_AUTO) ? BASE_OCT : active_base;
          end
        end
        default: base_use = active_base;
      endcase
    end

    if (!step_done) begin
      if (token.is_digit && (token.digit < base_use)) begin
        acc_next         = prod_full[VALUE_BITS-1:0] + VALUE_BITS'(token.digit);
        count_next       = count_inc;
        active_base_next = base_use;
        phase_next       = PH_DIGITS;
      end else begin
        // Terminating character: send the result and start a new string.
        emit             = 1'b1;
        phase_next       = PH_SPACE;
        negative_next    = 1'b0;
        active_base_next = '0;
        acc_next         = '0;
        count_next       = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_SPACE;
      negative    <= 1'b0;
      active_base <= '0;
      acc         <= '0;
      count       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop && emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        phase       <= phase_next;
        negative    <= negative_next;
        active_base <= active_base_next;
        acc         <= acc_next;
        count       <= count_next;
        if (emit) begin
          value     <= OUT_VALUE_BITS'(result);
          consumed  <= (count_wide > CONSUMED_MAX) ? OUT_COUNT_BITS'(CONSUMED_MAX)
                                                   : count_wide[OUT_COUNT_BITS-1:0];
        end
      end
    end
  end

endmodule

>>> src/ascii_to_integer_radix_core.sv
// Top level of the ASCII-to-integer parser: configuration registers and the three parts.
// Depends on a2i_pkg, a2i_front, a2i_queue and a2i_back.
//
//   Channel  | Handshake           | Payload
//   ---------+---------------------+-------------------------------
//   input    | in_valid / in_stall | ch[7:0]
//   result   | out_valid/out_stall | value[63:0], consumed[15:0]
//   config   | wr_en               | wr_index[0:0], wr_data[5:0]
//
// One character is taken per cycle while in_stall is low; the multiply-add of the parse engine
// is combinational around the acc register, which sets that rate. A terminating character
// passes through the token queue and then loads the result register. Reset (synchronous,
// active high) clears the queue, the parse state and the result valid flag, and loads
// radix 10 and signed mode on.
// A stalled result backs up through the two-entry token queue before in_stall rises.
module ascii_to_integer_radix_core import a2i_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [CH_BITS-1:0]        ch,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [OUT_VALUE_BITS-1:0] value,
  output logic [OUT_COUNT_BITS-1:0] consumed,
  input  logic                      wr_en,
  input  logic [INDEX_BITS-1:0]     wr_index,
  input  logic [WDATA_BITS-1:0]     wr_data
);

  logic [RADIX_BITS-1:0] radix;
  logic                  signed_mode;
  token_t                tok_in, tok_head;
  logic                  push, pop, full, not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix       <= RADIX_RESET;
      signed_mode <= SIGNED_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_RADIX:       radix       <= wr_data[RADIX_BITS-1:0];
        REG_SIGNED_MODE: signed_mode <= wr_data[0];
        default:         ;
      endcase
    end
  end

  a2i_front u_front (
    .in_valid (in_valid),
    .ch       (ch),
    .full     (full),
    .in_stall (in_stall),
    .push     (push),
    .token    (tok_in)
  );

  a2i_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (tok_in),
    .pop       (pop),
    .full      (full),
    .not_empty (not_empty),
    .head      (tok_head)
  );

  a2i_back u_back (
    .clk         (clk),
    .rst         (rst),
    .radix       (radix),
    .signed_mode (signed_mode),
    .tok_valid   (not_empty),
    .token       (tok_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .consumed    (consumed)
  );

endmodule

>>> src/a2i_checker.sv
// Port-level checks for the ASCII-to-integer parser, bound to the top level.
// Depends on a2i_pkg for port widths.
module a2i_checker import a2i_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic [CH_BITS-1:0]        ch,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [OUT_VALUE_BITS-1:0] value,
  input logic [OUT_COUNT_BITS-1:0] consumed,
  input logic                      wr_en,
  input logic [INDEX_BITS-1:0]     wr_index,
  input logic [WDATA_BITS-1:0]     wr_data
);

  // A stalled result transaction stays on the port unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(value) && $stable(consumed))
    else $error("result changed while stalled");

  // Reset leaves no result pending and the input open.
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset did not clear the handshakes");

  // The input only backs up when a result was held by the receiver.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stalled without a held result");

  // Once the receiver takes results again, the input reopens in the next cycle.
  a_stall_release: assert property (@(posedge clk) disable iff (rst)
    in_stall && !out_stall |=> !in_stall)
    else $error("input stayed stalled after the result side freed up");

endmodule

bind ascii_to_integer_radix_core a2i_checker u_a2i_checker (.*);

>>> tb/tb.sv
// Self-checking testbench for ascii_to_integer_radix_core: directed strings, then random text.
// Expected results come from a predictor kept inside this file; it depends only on a2i_pkg
// and the top level.
module tb;
  import a2i_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int SEGMENT_CHARS = 140;
  localparam int SEGMENTS      = 8;
  localparam int MAX_REPORTS   = 10;
  localparam int NOT_A_DIGIT   = 64;

  localparam logic [CH_BITS-1:0]    TERM_CHAR   = 8'h3B;
  localparam logic [RADIX_BITS-1:0] BASE_UNARY  = 6'd1;
  localparam logic [RADIX_BITS-1:0] BASE_BINARY = 6'd2;
  localparam logic [RADIX_BITS-1:0] BASE_ALNUM  = 6'd36;
  localparam logic [RADIX_BITS-1:0] BASE_WIDEST = 6'd63;

  typedef enum logic [1:0] {
    SCAN_SPACE,
    SCAN_START,
    SCAN_ZERO,
    SCAN_DIGITS
  } scan_phase_t;

  typedef struct packed {
    logic [OUT_VALUE_BITS-1:0] value;
    logic [OUT_COUNT_BITS-1:0] consumed;
  } parse_result_t;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic [CH_BITS-1:0]        ch        = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [OUT_VALUE_BITS-1:0] value;
  logic [OUT_COUNT_BITS-1:0] consumed;
  logic                      wr_en     = 1'b0;
  logic [INDEX_BITS-1:0]     wr_index  = '0;
  logic [WDATA_BITS-1:0]     wr_data   = '0;

  // Mirror of the configuration and of the parse state.
  logic [RADIX_BITS-1:0] cfg_radix  = RADIX_RESET;
  logic                  cfg_signed = SIGNED_RESET;
  scan_phase_t           scan       = SCAN_SPACE;
  logic                  neg        = 1'b0;
  logic [RADIX_BITS-1:0] base       = '0;
  logic [VALUE_BITS-1:0] acc        = '0;
  logic [COUNT_BITS-1:0] char_count = '0;

  parse_result_t expected_q[$];
  int            errors      = 0;
  int            cycle_count = 0;
  int            chars_sent  = 0;
  int            idle_pct    = 0;
  int            stall_pct   = 0;

  ascii_to_integer_radix_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .ch        (ch),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value),
    .consumed  (consumed),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit is_blank(input logic [CH_BITS-1:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic int digit_value(input logic [CH_BITS-1:0] c);
    if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return int'(c) - int'(CH_LOWER_A) + int'(ALPHA_FIRST);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return int'(c) - int'(CH_UPPER_A) + int'(ALPHA_FIRST);
    return NOT_A_DIGIT;
  endfunction

  function automatic void bump_count();
    if (char_count != '1) char_count++;
  endfunction

  // Advances the parse by one character and queues the result that a terminator produces.
  function automatic void parse_char(input logic [CH_BITS-1:0] c);
    int            d;
    parse_result_t r;
    if (scan == SCAN_SPACE) begin
      if (is_blank(c)) begin
        bump_count();
        return;
      end
      scan = SCAN_START;
      if (c == CH_PLUS || c == CH_MINUS) begin
        neg = (c == CH_MINUS);
        bump_count();
        return;
      end
    end
    if (scan == SCAN_START) begin
      if ((cfg_radix == BASE_AUTO || cfg_radix == BASE_HEX) && c == CH_ZERO) begin
        base = cfg_radix;
        acc  = '0;
        bump_count();
        scan = SCAN_ZERO;
        return;
      end
      base = (cfg_radix == BASE_AUTO) ? BASE_DEC : cfg_radix;
      scan = SCAN_DIGITS;
    end else if (scan == SCAN_ZERO) begin
      if (c == CH_LOWER_X || c == CH_UPPER_X) begin
        base = BASE_HEX;
        bump_count();
        scan = SCAN_DIGITS;
        return;
      end
      if (base == BASE_AUTO) base = BASE_OCT;
      scan = SCAN_DIGITS;
    end
    d = digit_value(c);
    if (d < int'(base)) begin
      acc = acc * {{(VALUE_BITS-RADIX_BITS){1'b0}}, base} + VALUE_BITS'(d);
      bump_count();
      return;
    end
    r.value    = (cfg_signed && neg) ? -acc : acc;
    r.consumed = char_count;
    expected_q.push_back(r);
    scan       = SCAN_SPACE;
    neg        = 1'b0;
    base       = '0;
    acc        = '0;
    char_count = '0;
  endfunction

  function automatic void check_result(input logic [OUT_VALUE_BITS-1:0] got_value,
                                       input logic [OUT_COUNT_BITS-1:0] got_consumed);
    parse_result_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("ERROR: unexpected result value %h consumed %0d", got_value, got_consumed);
      return;
    end
    want = expected_q.pop_front();
    if (want.value !== got_value || want.consumed !== got_consumed) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("ERROR: value exp %h got %h, consumed exp %0d got %0d",
                 want.value, got_value, want.consumed, got_consumed);
    end
  endfunction

  // Both channels are observed here, on the values present just before the edge.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (in_valid && !in_stall) parse_char(ch);
      if (out_valid && !out_stall) check_result(value, consumed);
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  task automatic send_char(input logic [CH_BITS-1:0] c);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes both registers once the parser has gone quiet.
  task automatic reconfigure(input logic [RADIX_BITS-1:0] r, input logic s);
    wait_for_results();
    wr_en    <= 1'b1;
    wr_index <= REG_RADIX;
    wr_data  <= r;
    @(posedge clk);
    wr_index <= REG_SIGNED_MODE;
    wr_data  <= {{(WDATA_BITS-1){1'b0}}, s};
    @(posedge clk);
    wr_en      <= 1'b0;
    cfg_radix  = r;
    cfg_signed = s;
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      1: begin
        idle_pct  = 81;
        stall_pct = 0;
      end
      2: begin
        idle_pct  = 0;
        stall_pct = 81;
      end
      default: begin
        idle_pct  = 26;
        stall_pct = 26;
      end
    endcase
  endtask

  function automatic logic [CH_BITS-1:0] blank_char();
    if ($urandom_range(5) == 0) return CH_SPACE;
    return CH_TAB + CH_BITS'($urandom_range(4));
  endfunction

  function automatic logic [CH_BITS-1:0] digit_char(input int v);
    if (v < 10) return CH_ZERO + CH_BITS'(v);
    if ($urandom_range(1) == 1) return CH_LOWER_A + CH_BITS'(v - 10);
    return CH_UPPER_A + CH_BITS'(v - 10);
  endfunction

  // Mostly well-formed numbers with random content; some strings are raw noise.
  task automatic send_random_string();
    int eff;
    int n;
    int i;
    if ($urandom_range(99) < 12) begin
      n = $urandom_range(1, 6);
      for (i = 0; i < n; i++) send_char(CH_BITS'($urandom_range(255)));
      return;
    end
    n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    for (i = 0; i < n; i++) send_char(blank_char());
    case ($urandom_range(3))
      0: send_char(CH_PLUS);
      1: send_char(CH_MINUS);
      default: ;
    endcase
    eff = (cfg_radix == BASE_AUTO) ? int'(BASE_DEC) : int'(cfg_radix);
    if ((cfg_radix == BASE_AUTO || cfg_radix == BASE_HEX) && $urandom_range(1) == 1) begin
      send_char(CH_ZERO);
      case ($urandom_range(2))
        0: begin
          send_char(CH_LOWER_X);
          eff = int'(BASE_HEX);
        end
        1: begin
          send_char(CH_UPPER_X);
          eff = int'(BASE_HEX);
        end
        default: if (cfg_radix == BASE_AUTO) eff = int'(BASE_OCT);
      endcase
    end
    if (eff > 36) eff = 36;
    n = ($urandom_range(9) == 0) ? $urandom_range(14, 30) : $urandom_range(0, 8);
    for (i = 0; i < n; i++) send_char(digit_char($urandom_range(eff - 1)));
    // A terminator that happens to be a digit just extends the string.
    send_char(CH_BITS'($urandom_range(255)));
  endtask

  task automatic test_reset_defaults();
    set_idling(3);
    send_char(CH_TAB);
    send_char(CH_CR);
    send_text(" -9");
    send_char(8'hFF);
    send_char(CH_PLUS);
    send_char(8'h00);
  endtask

  // The sign is taken but ignored; a bare 0x prefix still counts.
  task automatic test_hex_prefix();
    reconfigure(BASE_HEX, 1'b0);
    send_text("-0xg");
    send_text("0XfF");
    send_char(8'h00);
  endtask

  task automatic test_auto_base();
    reconfigure(BASE_AUTO, 1'b1);
    send_text("-0x1A ");
    send_text("0178");
  endtask

  task automatic test_radix_extremes();
    reconfigure(BASE_UNARY, 1'b1);
    send_text("01");
    reconfigure(BASE_WIDEST, 1'b0);
    send_text("zZ.");
  endtask

  task automatic test_random_strings();
    int                    seg;
    int                    start;
    logic [RADIX_BITS-1:0] r;
    logic                  s;
    for (seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        0: begin
          r = BASE_DEC;
          s = 1'b1;
        end
        1: begin
          r = BASE_AUTO;
          s = 1'b1;
        end
        2: begin
          r = BASE_HEX;
          s = 1'b0;
        end
        3: begin
          r = BASE_ALNUM;
          s = 1'b1;
        end
        4: begin
          r = BASE_UNARY;
          s = 1'b0;
        end
        5: begin
          r = BASE_WIDEST;
          s = 1'b1;
        end
        6: begin
          r = BASE_BINARY;
          s = 1'b0;
        end
        default: begin
          r = RADIX_BITS'($urandom_range(63));
          s = 1'($urandom_range(1));
        end
      endcase
      // Close any open string so the parser is idle before the registers change.
      send_char(TERM_CHAR);
      reconfigure(r, s);
      set_idling(seg % 4);
      start = chars_sent;
      while (chars_sent - start < SEGMENT_CHARS) send_random_string();
    end
    send_char(TERM_CHAR);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_hex_prefix();
    test_auto_base();
    test_radix_extremes();
    test_random_strings();
    wait_for_results();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
